/* rtl/tfn_pkg.sv */
// Package for the triangle face normal unit: widths, cell payload types.
// Used by every module in the rtl folder; depends on nothing.
package tfn_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int NORMAL_WIDTH = 16;
   localparam int FRAC_BITS    = NORMAL_WIDTH - 2;

   localparam int EDGE_W = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * EDGE_W;
   localparam int CRS_W  = PROD_W + 1;
   localparam int MAG_W  = PROD_W;
   localparam int HALF_W = MAG_W / 2;
   localparam int HI_W   = MAG_W - HALF_W;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int RES_W  = FRAC_BITS + 1;
   localparam int DW     = SUM_W + 2 * FRAC_BITS + 6;
   localparam int KW     = $clog2(RES_W);
   localparam int SHW    = $clog2(2 * RES_W + 4);
   localparam int NCELLS = RES_W;

   typedef struct packed {
      logic signed [DW-1:0] d;
      logic signed [DW-1:0] q;
      logic [RES_W-1:0]     r;
      logic                 neg;
   } lane_type;

   typedef struct packed {
      logic                 valid;
      logic                 degen;
      logic signed [DW-1:0] s;
      lane_type [2:0]       lane;
   } cell_type;

endpackage

/* rtl/tfn_front.sv */
// Front pipeline: edges, cross product, squares and residual setup.
// Depends on tfn_pkg; feeds the first tfn_cell of the chain.
module tfn_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0]   a [3],
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0]   b [3],
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0]   c [3],
   output tfn_pkg::cell_type                        out_cell
);

   logic [7:0] valid_ff;
   logic [7:0] valid_in;

   logic signed [tfn_pkg::EDGE_W-1:0] e1_ff [3];
   logic signed [tfn_pkg::EDGE_W-1:0] e2_ff [3];
   logic signed [tfn_pkg::PROD_W-1:0] p_ff  [6];
   logic signed [tfn_pkg::CRS_W-1:0]  n_ff  [3];
   logic signed [tfn_pkg::CRS_W-1:0]  n_abs [3];
   logic [tfn_pkg::MAG_W-1:0]         mag_ff [3];
   logic [2:0]                        neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [2*tfn_pkg::HALF_W-1:0]      ll_ff [3];
   logic [tfn_pkg::HALF_W+tfn_pkg::HI_W-1:0] hl_ff [3];
   logic [2*tfn_pkg::HI_W-1:0]        hh_ff [3];
   logic [tfn_pkg::SQ_W-1:0]          n2_ff [3];
   logic [tfn_pkg::SQ_W-1:0]          n2s_ff [3];
   logic [tfn_pkg::SUM_W-1:0]         s_ff;
   tfn_pkg::cell_type                 cell_ff, cell_in;

   assign valid_in = {valid_ff[6:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_abs[i] = n_ff[i][tfn_pkg::CRS_W-1] ? -n_ff[i] : n_ff[i];
      end
      cell_in       = '0;
      cell_in.valid = valid_ff[6];
      cell_in.degen = (s_ff == '0);
      cell_in.s     = tfn_pkg::DW'(s_ff);
      for (int i = 0; i < 3; i++) begin
         cell_in.lane[i].d   = (tfn_pkg::DW'(n2s_ff[i]) <<< (2 * tfn_pkg::FRAC_BITS + 2))
                               - tfn_pkg::DW'(s_ff);
         cell_in.lane[i].q   = -tfn_pkg::DW'(s_ff);
         cell_in.lane[i].r   = '0;
         cell_in.lane[i].neg = neg6_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= tfn_pkg::EDGE_W'(b[i]) - tfn_pkg::EDGE_W'(a[i]);
            e2_ff[i] <= tfn_pkg::EDGE_W'(c[i]) - tfn_pkg::EDGE_W'(a[i]);
         end
         p_ff[0] <= e1_ff[1] * e2_ff[2];
         p_ff[1] <= e1_ff[2] * e2_ff[1];
         p_ff[2] <= e1_ff[2] * e2_ff[0];
         p_ff[3] <= e1_ff[0] * e2_ff[2];
         p_ff[4] <= e1_ff[0] * e2_ff[1];
         p_ff[5] <= e1_ff[1] * e2_ff[0];
         for (int i = 0; i < 3; i++) begin
            n_ff[i]   <= tfn_pkg::CRS_W'(p_ff[2*i]) - tfn_pkg::CRS_W'(p_ff[2*i+1]);
            mag_ff[i] <= n_abs[i][tfn_pkg::MAG_W-1:0];
            neg3_ff[i] <= n_ff[i][tfn_pkg::CRS_W-1];
            // Square split in halves keeps each multiplier narrow.
            ll_ff[i] <= mag_ff[i][tfn_pkg::HALF_W-1:0] * mag_ff[i][tfn_pkg::HALF_W-1:0];
            hl_ff[i] <= mag_ff[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W]
                        * mag_ff[i][tfn_pkg::HALF_W-1:0];
            hh_ff[i] <= mag_ff[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W]
                        * mag_ff[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W];
            n2_ff[i] <= (tfn_pkg::SQ_W'(hh_ff[i]) << (2 * tfn_pkg::HALF_W))
                        + (tfn_pkg::SQ_W'(hl_ff[i]) << (tfn_pkg::HALF_W + 1))
                        + tfn_pkg::SQ_W'(ll_ff[i]);
            n2s_ff[i] <= n2_ff[i];
         end
         neg4_ff <= neg3_ff;
         neg5_ff <= neg4_ff;
         neg6_ff <= neg5_ff;
         s_ff <= tfn_pkg::SUM_W'(n2_ff[0]) + tfn_pkg::SUM_W'(n2_ff[1])
                 + tfn_pkg::SUM_W'(n2_ff[2]);
         cell_ff <= cell_in;
      end
   end

   always_comb begin
      out_cell       = cell_ff;
      out_cell.valid = valid_ff[7];
   end

endmodule

/* rtl/tfn_cell.sv */
// One cell of the normalizing chain: decides one result bit for all three lanes.
// Depends on tfn_pkg; instantiated in a row by the top level.
module tfn_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic [tfn_pkg::KW-1:0]   bit_pos,
   input  tfn_pkg::cell_type        in_cell,
   output tfn_pkg::cell_type        out_cell
);

   tfn_pkg::cell_type cell_ff, cell_in;
   logic              valid_ff;
   logic [tfn_pkg::SHW-1:0] sh_q, sh_s, sh_a;
   logic signed [tfn_pkg::DW-1:0] trial [3];

   assign sh_a = tfn_pkg::SHW'(bit_pos) + tfn_pkg::SHW'(1);
   assign sh_q = tfn_pkg::SHW'(bit_pos) + tfn_pkg::SHW'(2);
   assign sh_s = (tfn_pkg::SHW'(bit_pos) << 1) + tfn_pkg::SHW'(2);

   // Residual d = 4 n^2 2^2F - t^2 S with t = 2r - 1 and q = t S.
   // Raising r by 2^k moves t by 2^(k+1); the bit is kept while d stays nonnegative.
   always_comb begin
      cell_in = in_cell;
      for (int i = 0; i < 3; i++) begin
         trial[i] = in_cell.lane[i].d - (in_cell.lane[i].q <<< sh_q)
                    - (in_cell.s <<< sh_s);
         if (!trial[i][tfn_pkg::DW-1]) begin
            cell_in.lane[i].d = trial[i];
            cell_in.lane[i].q = in_cell.lane[i].q + (in_cell.s <<< sh_a);
            cell_in.lane[i].r = in_cell.lane[i].r | (tfn_pkg::RES_W'(1) << bit_pos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_cell.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   always_comb begin
      out_cell       = cell_ff;
      out_cell.valid = valid_ff;
   end

endmodule

/* rtl/triangle_face_normal_unit.sv */
// Top level of the triangle face normal unit.
// Depends on tfn_pkg, tfn_front and tfn_cell.
//
// Usage: each request transaction carries the three vertices A, B and C of a
// triangle as signed Q7.8 coordinates. The response transaction carries the
// unit normal of the face, (B - A) x (C - A) scaled to length one, as signed
// Q1.14 components rounded to nearest with ties away from zero. When the cross
// product is the zero vector the components are zero and degenerate is set.
// Both channels use valid and ready handshakes.
// Eight front stages form the edges, cross product, squared terms and the
// starting residual, then a row of 15 cells settles one result bit per cell,
// and an output register holds the response.
// Throughput is one transaction per cycle while the receiver does not stall;
// the whole pipeline moves together.
// When the receiver stalls with a response waiting, the pipeline freezes and
// req_ready drops until the response is taken; stalled data is held in place.
// Reset clears all valid bits, so no response appears until new requests.
module triangle_face_normal_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_ax,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_ay,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_az,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_bx,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_by_coord,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_bz,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_cx,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_cy,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_cz,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [tfn_pkg::NORMAL_WIDTH-1:0] rsp_nx,
   output logic signed [tfn_pkg::NORMAL_WIDTH-1:0] rsp_ny,
   output logic signed [tfn_pkg::NORMAL_WIDTH-1:0] rsp_nz,
   output logic                                   rsp_degenerate
);

   logic en;
   logic rsp_valid_ff;
   logic signed [tfn_pkg::NORMAL_WIDTH-1:0] comp_ff [3];
   logic signed [tfn_pkg::NORMAL_WIDTH-1:0] comp_in [3];
   logic degen_ff;
   logic signed [tfn_pkg::COORD_WIDTH-1:0] va [3];
   logic signed [tfn_pkg::COORD_WIDTH-1:0] vb [3];
   logic signed [tfn_pkg::COORD_WIDTH-1:0] vc [3];
   tfn_pkg::cell_type chain [tfn_pkg::NCELLS+1];
   tfn_pkg::cell_type last;

   // The whole pipeline advances whenever the output register can take data.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   assign va = '{req_ax, req_ay, req_az};
   assign vb = '{req_bx, req_by_coord, req_bz};
   assign vc = '{req_cx, req_cy, req_cz};

   tfn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .a        (va),
      .b        (vb),
      .c        (vc),
      .out_cell (chain[0])
   );

   // Cell j decides result bit NCELLS-1-j, most significant bit first.
   for (genvar j = 0; j < tfn_pkg::NCELLS; j++) begin : g_cell
      tfn_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .bit_pos  (tfn_pkg::KW'(tfn_pkg::NCELLS - 1 - j)),
         .in_cell  (chain[j]),
         .out_cell (chain[j+1])
      );
   end

   assign last = chain[tfn_pkg::NCELLS];

   // Apply each cross product sign to its magnitude; zero when degenerate.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (last.degen) begin
            comp_in[i] = '0;
         end else if (last.lane[i].neg) begin
            comp_in[i] = -tfn_pkg::NORMAL_WIDTH'(last.lane[i].r);
         end else begin
            comp_in[i] = tfn_pkg::NORMAL_WIDTH'(last.lane[i].r);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         comp_ff  <= comp_in;
         degen_ff <= last.degen;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_nx         = comp_ff[0];
   assign rsp_ny         = comp_ff[1];
   assign rsp_nz         = comp_ff[2];
   assign rsp_degenerate = degen_ff;

endmodule

/* rtl/tfn_checker.sv */
// Port-level checks for the triangle face normal unit, bound to the top level.
// Depends on tfn_pkg and triangle_face_normal_unit.
module tfn_assertions (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [tfn_pkg::NORMAL_WIDTH-1:0] rsp_nx,
   input logic signed [tfn_pkg::NORMAL_WIDTH-1:0] rsp_ny,
   input logic signed [tfn_pkg::NORMAL_WIDTH-1:0] rsp_nz,
   input logic                                    rsp_degenerate
);

   localparam logic signed [tfn_pkg::NORMAL_WIDTH-1:0] ONE =
      tfn_pkg::NORMAL_WIDTH'(1) << tfn_pkg::FRAC_BITS;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output space");

   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_nx == 0 && rsp_ny == 0 && rsp_nz == 0)
      else $error("degenerate response with nonzero components");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_nx <= ONE && rsp_nx >= -ONE && rsp_ny <= ONE
                    && rsp_ny >= -ONE && rsp_nz <= ONE && rsp_nz >= -ONE)
      else $error("normal component out of unit range");

endmodule

bind triangle_face_normal_unit tfn_assertions u_tfn_assertions (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_nx         (rsp_nx),
   .rsp_ny         (rsp_ny),
   .rsp_nz         (rsp_nz),
   .rsp_degenerate (rsp_degenerate)
);

/* test/tfn_checker.sv */
// Checker for the triangle face normal unit: watches both channels, predicts
// each unit normal with exact integer arithmetic and compares it with the response.
// Depends on tfn_pkg.
module tfn_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_ax,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_ay,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_az,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_bx,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_by_coord,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_bz,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_cx,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_cy,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0] req_cz,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [tfn_pkg::NORMAL_WIDTH-1:0] rsp_nx,
   input  logic signed [tfn_pkg::NORMAL_WIDTH-1:0] rsp_ny,
   input  logic signed [tfn_pkg::NORMAL_WIDTH-1:0] rsp_nz,
   input  logic                                   rsp_degenerate,
   output int                                     fail_count,
   output int                                     pending_normals,
   output int                                     normals_checked
);

   localparam int F  = tfn_pkg::FRAC_BITS;
   localparam int NW = tfn_pkg::NORMAL_WIDTH;

   typedef struct {
      logic signed [NW-1:0] nx;
      logic signed [NW-1:0] ny;
      logic signed [NW-1:0] nz;
      logic                 degen;
   } normal_type;

   normal_type expected_normals[$];

   // Rounded magnitude of one component: the largest r with
   // (2r-1)^2 * S <= 4 * n^2 * 2^(2F), found by bisection.
   function automatic longint unsigned component_magnitude(logic signed [127:0] n,
                                                          logic [255:0] s);
      logic [255:0] rhs;
      logic [255:0] lhs;
      logic [255:0] t;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      rhs = ((n < 0) ? 256'(-n) : 256'(n));
      rhs = (rhs * rhs) << (2 * F + 2);
      lo = 0;
      hi = longint'(1) << F;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = 256'(2 * mid - 1);
         lhs = s * t * t;
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic normal_type face_normal(logic signed [127:0] a[3],
                                              logic signed [127:0] b[3],
                                              logic signed [127:0] c[3]);
      logic signed [127:0] e1[3];
      logic signed [127:0] e2[3];
      logic signed [127:0] n[3];
      logic [255:0] s;
      longint unsigned m;
      logic signed [NW-1:0] comp[3];
      normal_type r;
      for (int i = 0; i < 3; i++) begin
         e1[i] = b[i] - a[i];
         e2[i] = c[i] - a[i];
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      s = 0;
      for (int i = 0; i < 3; i++)
         s += 256'(n[i] < 0 ? -n[i] : n[i]) * 256'(n[i] < 0 ? -n[i] : n[i]);
      if (s == 0) begin
         r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         m = component_magnitude(n[i], s);
         comp[i] = (n[i] < 0) ? NW'(-m) : NW'(m);
      end
      r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2]; r.degen = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      normals_checked = 0;
   end

   assign pending_normals = expected_normals.size();

   always @(posedge clock) begin
      logic signed [127:0] a[3];
      logic signed [127:0] b[3];
      logic signed [127:0] c[3];
      normal_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            a[0] = req_ax; a[1] = req_ay; a[2] = req_az;
            b[0] = req_bx; b[1] = req_by_coord; b[2] = req_bz;
            c[0] = req_cx; c[1] = req_cy; c[2] = req_cz;
            expected_normals.push_back(face_normal(a, b, c));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_normals.size() == 0) begin
               report_mismatch("outstanding requests", 0, 1);
            end else begin
               want = expected_normals.pop_front();
               normals_checked++;
               if (rsp_nx !== want.nx) report_mismatch("nx", rsp_nx, want.nx);
               if (rsp_ny !== want.ny) report_mismatch("ny", rsp_ny, want.ny);
               if (rsp_nz !== want.nz) report_mismatch("nz", rsp_nz, want.nz);
               if (rsp_degenerate !== want.degen)
                  report_mismatch("degenerate", rsp_degenerate, want.degen);
            end
         end
      end
   end
endmodule

/* test/tb.sv */
// Top of the triangle face normal testbench: clock, reset, request stimulus,
// response stalls and the verdict. Depends on tfn_pkg, tfn_checker and the unit.
module tb;

   localparam int CW = tfn_pkg::COORD_WIDTH;
   localparam int NW = tfn_pkg::NORMAL_WIDTH;

   localparam int RANDOM_TRIANGLES = 400;
   localparam int QUIET_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 40;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [CW-1:0] req_ax, req_ay, req_az;
   logic signed [CW-1:0] req_bx, req_by_coord, req_bz;
   logic signed [CW-1:0] req_cx, req_cy, req_cz;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [NW-1:0] rsp_nx, rsp_ny, rsp_nz;
   logic rsp_degenerate;
   int fail_count;
   int pending_normals;
   int normals_checked;
   int quiet_cycles;
   int triangles_sent;
   int degenerate_sent;
   // Once set, neither side idles any more.
   bit steady_phase;
   // Set while the long receiver hold-off runs.
   bit hold_off;

   triangle_face_normal_unit dut (.*);

   tfn_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Each request transaction presents a triangle and holds it until accepted.
   task automatic send_triangle(logic signed [CW-1:0] v[9]);
      req_valid    <= 1'b1;
      req_ax       <= v[0];
      req_ay       <= v[1];
      req_az       <= v[2];
      req_bx       <= v[3];
      req_by_coord <= v[4];
      req_bz       <= v[5];
      req_cx       <= v[6];
      req_cy       <= v[7];
      req_cz       <= v[8];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      triangles_sent++;
   endtask

   // Between transactions the sender sometimes goes quiet for a burst.
   task automatic maybe_idle_sender();
      int gap;
      if (!steady_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic signed [CW-1:0] random_coord();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1: return CW'($signed($urandom_range(0, 64)) - 32);
         default: return CW'($urandom);
      endcase
   endfunction

   // Receiver: random stall bursts, one long hold-off, then steady acceptance.
   initial begin
      int burst;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!steady_phase && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 14);
            rsp_ready <= 1'b0;
            repeat (burst - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: a long stretch with no transaction on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout with %0d responses outstanding", pending_normals);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      logic signed [CW-1:0] v[9];
      int pick;
      quiet_cycles = 0;
      triangles_sent = 0;
      degenerate_sent = 0;
      steady_phase = 1'b0;
      hold_off = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_ax, req_ay, req_az, req_bx, req_by_coord, req_bz, req_cx, req_cy, req_cz} = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: all coordinates equal (degenerate), collinear points,
      // axis-aligned faces, and full-scale extremes that stretch the edges.
      for (int d = 0; d < 14; d++) begin
         foreach (v[i]) v[i] = '0;
         case (d)
            0: ;
            1: foreach (v[i]) v[i] = 16'sh7fff;
            2: foreach (v[i]) v[i] = 16'sh8000;
            3: begin v[3] = 16'sh0100; v[6] = 16'sh0200; end
            4: begin v[3] = 16'sh0100; v[7] = 16'sh0100; end
            5: begin v[4] = 16'sh0100; v[8] = 16'sh0100; end
            6: begin v[5] = 16'sh0100; v[6] = 16'sh0100; end
            7: begin v[3] = 16'sh0100; v[8] = 16'sh0100; end
            8: begin
               v[0] = 16'sh8000; v[1] = 16'sh8000; v[2] = 16'sh8000;
               v[3] = 16'sh7fff; v[7] = 16'sh7fff; v[5] = 16'sh8000;
            end
            9: begin
               v[3] = 16'sh7fff; v[4] = 16'sh8000; v[5] = 16'sh7fff;
               v[6] = 16'sh8000; v[7] = 16'sh7fff; v[8] = 16'sh7fff;
            end
            10: begin v[3] = 16'sh0001; v[7] = 16'sh0001; v[8] = 16'sh0001; end
            11: begin v[3] = 16'sh0001; v[4] = 16'sh0001; v[6] = 16'sh0001; end
            12: begin v[3] = 16'shffff; v[4] = 16'shffff; v[8] = 16'shffff; end
            13: begin v[3] = 16'sh0003; v[7] = 16'sh0004; v[8] = 16'sh0005; end
            default: ;
         endcase
         send_triangle(v);
      end

      // Random part: mostly general triangles, some made degenerate on purpose.
      for (int k = 0; k < RANDOM_TRIANGLES; k++) begin
         if (k == 100) hold_off = 1'b1;
         if (k == RANDOM_TRIANGLES - 60) steady_phase = 1'b1;
         foreach (v[i]) v[i] = random_coord();
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            // B and C on the line through A: C - A = 2 (B - A) when it fits.
            for (int i = 0; i < 3; i++) begin
               v[i] = CW'($signed($urandom_range(0, 8000)) - 4000);
               v[3 + i] = v[i] + CW'($signed($urandom_range(0, 4000)) - 2000);
               v[6 + i] = CW'(2 * v[3 + i] - v[i]);
            end
            degenerate_sent++;
         end else if (pick == 1) begin
            for (int i = 0; i < 3; i++) v[3 + i] = v[i];
            degenerate_sent++;
         end
         send_triangle(v);
         maybe_idle_sender();
      end
      req_valid <= 1'b0;

      while (pending_normals != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d triangles (%0d built degenerate), %0d responses checked",
               triangles_sent, degenerate_sent, normals_checked);
      $display("stimulus included full-scale coordinates, axis faces and a long stall");
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
